// ===== hdl/gcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcsc_pkg
// Shared types and constants for the Gray coordinate stability check unit.
// ----------------------------------------------------------------------------
package gcsc_pkg;

    // Fixed field widths of the request and result items.
    localparam int CODE_W     = 8;
    localparam int NUM_CODES  = 4;
    localparam int AXES       = 2;
    localparam int MAX_BOARDS = 2;
    localparam int CNT_W      = 2;
    localparam int TOL_W      = 8;

    // Tolerance after reset.
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

    typedef logic [CODE_W-1:0] t_pos;

    // One decoded request as it travels through the queue.
    typedef struct packed {
        logic                   oob;
        logic                   board;
        logic                   axis;
        t_pos [NUM_CODES-1:0]   pos;
    } t_item;

    // One result item.
    typedef struct packed {
        logic                   ignored;
        logic                   stable;
        logic [CNT_W-1:0]       passes_done;
        logic                   complete;
        logic [MAX_BOARDS-1:0]  boards_seen;
        t_pos [NUM_CODES-1:0]   pos;
    } t_result;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/gcsc_if.sv =====
// ----------------------------------------------------------------------------
// gcsc_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gcsc_in_if;
    logic       valid;
    logic       ready;
    logic       board;
    logic       axis;
    logic [7:0] sensor_code_0;
    logic [7:0] sensor_code_1;
    logic [7:0] sensor_code_2;
    logic [7:0] sensor_code_3;

    modport source (
        output valid, board, axis, sensor_code_0, sensor_code_1,
               sensor_code_2, sensor_code_3,
        input  ready
    );
    modport sink (
        input  valid, board, axis, sensor_code_0, sensor_code_1,
               sensor_code_2, sensor_code_3,
        output ready
    );
endinterface

interface gcsc_out_if;
    logic       valid;
    logic       ready;
    logic       ignored;
    logic       stable;
    logic [1:0] passes_done;
    logic       complete;
    logic [1:0] boards_seen;
    logic [7:0] position_0;
    logic [7:0] position_1;
    logic [7:0] position_2;
    logic [7:0] position_3;

    modport source (
        output valid, ignored, stable, passes_done, complete, boards_seen,
               position_0, position_1, position_2, position_3,
        input  ready
    );
    modport sink (
        input  valid, ignored, stable, passes_done, complete, boards_seen,
               position_0, position_1, position_2, position_3,
        output ready
    );
endinterface

// ===== hdl/gcsc_front.sv =====
// ----------------------------------------------------------------------------
// gcsc_front
// Request side: accepts requests, decodes the Gray codes and classifies the
// board number before the item enters the queue.
// ----------------------------------------------------------------------------
module gcsc_front #(
    parameter int SENSORS   = 4,
    parameter int BOARDS    = 2,
    parameter int CODE_BITS = 8
) (
    gcsc_in_if.sink           i_req,
    input  gcsc_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output gcsc_pkg::t_item   o_item
);

    localparam logic HAS_B1 = (BOARDS > 1);

    gcsc_pkg::t_pos [gcsc_pkg::NUM_CODES-1:0] w_codes;
    gcsc_pkg::t_pos [gcsc_pkg::NUM_CODES-1:0] w_masked;
    gcsc_pkg::t_pos [gcsc_pkg::NUM_CODES-1:0] w_bin;

    // Mask each code to the code width, then take the prefix XOR from the top.
    always_comb begin
        w_codes[0] = i_req.sensor_code_0;
        w_codes[1] = i_req.sensor_code_1;
        w_codes[2] = i_req.sensor_code_2;
        w_codes[3] = i_req.sensor_code_3;
        for (int s = 0; s < gcsc_pkg::NUM_CODES; s++) begin
            for (int j = 0; j < gcsc_pkg::CODE_W; j++) begin
                w_masked[s][j] = (j < CODE_BITS) ? w_codes[s][j] : 1'b0;
            end
            for (int j = 0; j < gcsc_pkg::CODE_W; j++) begin
                w_bin[s][j] = ^(w_masked[s] >> j);
            end
            if (s >= SENSORS) begin
                w_bin[s] = '0;
            end
        end
    end

    // Accept whenever the queue has room.
    assign i_req.ready = ~i_q_stat.full;
    assign o_push      = i_req.valid & ~i_q_stat.full;

    // A board number beyond the fitted boards is flagged for the back end.
    always_comb begin
        o_item.oob   = i_req.board & ~HAS_B1;
        o_item.board = i_req.board;
        o_item.axis  = i_req.axis;
        o_item.pos   = w_bin;
    end

endmodule

// ===== hdl/gcsc_queue.sv =====
// ----------------------------------------------------------------------------
// gcsc_queue
// Two-entry queue between the request side and the update side.
// ----------------------------------------------------------------------------
module gcsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gcsc_pkg::t_item   i_item,
    input  logic              i_pop,
    output gcsc_pkg::t_item   o_item,
    output gcsc_pkg::t_q_stat o_stat
);

    gcsc_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count[1];
    assign o_stat.empty = (r_count == 2'd0);

endmodule

// ===== hdl/gcsc_back.sv =====
// ----------------------------------------------------------------------------
// gcsc_back
// Update side: pass counters, previous-pass positions, stability test,
// board seen flags, tolerance register and the result register.
// ----------------------------------------------------------------------------
module gcsc_back #(
    parameter int PASSES  = 2,
    parameter int SENSORS = 4,
    parameter int BOARDS  = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gcsc_pkg::TOL_W-1:0]    i_cfg_wdata,
    input  gcsc_pkg::t_q_stat             i_q_stat,
    input  gcsc_pkg::t_item               i_item,
    output logic                          o_pop,
    gcsc_out_if.source                    o_res
);

    localparam int SLOTS = BOARDS * gcsc_pkg::AXES;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [gcsc_pkg::CNT_W-1:0] PASS_LIM = gcsc_pkg::CNT_W'(PASSES);

    logic [gcsc_pkg::TOL_W-1:0]                 r_tol;
    logic [gcsc_pkg::CNT_W-1:0]                 r_cnt  [SLOTS];
    logic [SENSORS-1:0][gcsc_pkg::CODE_W-1:0]   r_prev [SLOTS];
    logic [BOARDS-1:0]                          r_seen;
    logic                                       r_out_vld;
    gcsc_pkg::t_result                          r_res;

    logic [1:0]                                 w_slot;
    logic [IDX_W-1:0]                           w_idx;
    logic [gcsc_pkg::CNT_W-1:0]                 w_cnt;
    logic                                       w_full_pass;
    logic [SENSORS-1:0]                         w_bad;
    gcsc_pkg::t_pos                             w_diff [SENSORS];
    logic                                       w_stable;
    logic [gcsc_pkg::CNT_W-1:0]                 w_next_cnt;
    logic [BOARDS-1:0]                          n_seen;
    logic                                       w_upd;
    gcsc_pkg::t_result                          n_res;

    // Take the next item when the result register is free or being drained.
    assign o_pop = ~i_q_stat.empty & (~r_out_vld | o_res.ready);

    // Counter lookup for the addressed board and axis.
    always_comb begin
        w_slot      = {i_item.board, i_item.axis};
        w_idx       = w_slot[IDX_W-1:0];
        w_cnt       = r_cnt[w_idx];
        w_full_pass = (w_cnt >= PASS_LIM);
    end

    // Per-sensor distance to the previous pass against the tolerance.
    always_comb begin
        for (int s = 0; s < SENSORS; s++) begin
            if (r_prev[w_idx][s] > i_item.pos[s]) begin
                w_diff[s] = r_prev[w_idx][s] - i_item.pos[s];
            end else begin
                w_diff[s] = i_item.pos[s] - r_prev[w_idx][s];
            end
            w_bad[s] = (w_diff[s] > r_tol);
        end
        w_stable   = (w_cnt == '0) | ~(|w_bad);
        w_next_cnt = w_stable ? (w_cnt + 1'b1) : '0;
    end

    // Seen flags after this request.
    always_comb begin
        for (int i = 0; i < BOARDS; i++) begin
            n_seen[i] = r_seen[i] | (~i_item.oob & (i_item.board == 1'(i)));
        end
    end

    // Counter and position store are written only for a live board and axis that has not completed its passes.
    assign w_upd = o_pop & ~i_item.oob & ~w_full_pass;

    // Result assembly.
    always_comb begin
        n_res.boards_seen = gcsc_pkg::MAX_BOARDS'(n_seen);
        n_res.pos         = i_item.pos;
        if (i_item.oob) begin
            n_res.ignored     = 1'b1;
            n_res.stable      = 1'b0;
            n_res.passes_done = '0;
            n_res.complete    = 1'b0;
        end else if (w_full_pass) begin
            n_res.ignored     = 1'b1;
            n_res.stable      = 1'b0;
            n_res.passes_done = w_cnt;
            n_res.complete    = 1'b1;
        end else begin
            n_res.ignored     = 1'b0;
            n_res.stable      = w_stable;
            n_res.passes_done = w_next_cnt;
            n_res.complete    = (w_next_cnt >= PASS_LIM);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= gcsc_pkg::TOL_RESET;
            r_seen    <= BOARDS'(1);
            r_out_vld <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_seen <= n_seen;
            end
            if (w_upd) begin
                r_cnt[w_idx] <= w_next_cnt;
            end
            if (o_pop) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: latest pass positions and the result register.
    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_prev[w_idx][s] <= i_item.pos[s];
            end
        end
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    // Result channel.
    always_comb begin
        o_res.valid       = r_out_vld;
        o_res.ignored     = r_res.ignored;
        o_res.stable      = r_res.stable;
        o_res.passes_done = r_res.passes_done;
        o_res.complete    = r_res.complete;
        o_res.boards_seen = r_res.boards_seen;
        o_res.position_0  = r_res.pos[0];
        o_res.position_1  = r_res.pos[1];
        o_res.position_2  = r_res.pos[2];
        o_res.position_3  = r_res.pos[3];
    end

endmodule

// ===== hdl/gray_coordinate_stability_check_unit.sv =====
// ----------------------------------------------------------------------------
// gray_coordinate_stability_check_unit
// Top level of the Gray coordinate stability check.
// ----------------------------------------------------------------------------
// Usage:
// - i_req carries one calibration request: board, axis and four Gray codes.
//   It is accepted when valid and ready are both high at a rising edge.
// - o_res carries one result per request, in request order.
// - i_cfg_we / i_cfg_wdata write the tolerance; write it only while idle.
// - A request accepted at i_req is written into the queue, then into the
//   result register when it is popped, and shows on o_res from there on.
// - Throughput is one request per cycle while the receiver takes results,
//   set by the counter read-compare-write in the update stage.
// - A two-entry queue sits between the request and update sides, so i_req
//   stays ready while a finished result waits in the output register.
// - When the receiver stalls, the result holds and the queue fills; i_req
//   drops ready after two further requests.
// - Synchronous active-low reset clears counters, sets the seen flag of
//   board 0, restores tolerance 3 and empties the queue and output.
// ----------------------------------------------------------------------------
module gray_coordinate_stability_check_unit #(
    parameter int PASSES    = 2,
    parameter int SENSORS   = 4,
    parameter int BOARDS    = 2,
    parameter int CODE_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gcsc_pkg::TOL_W-1:0] i_cfg_wdata,
    gcsc_in_if.sink                    i_req,
    gcsc_out_if.source                 o_res
);

    logic              w_push;
    logic              w_pop;
    gcsc_pkg::t_item   w_in_item;
    gcsc_pkg::t_item   w_q_item;
    gcsc_pkg::t_q_stat w_q_stat;

    // Request side: decode and classify.
    gcsc_front #(
        .SENSORS   (SENSORS),
        .BOARDS    (BOARDS),
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .i_req    (i_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    // Queue between the two sides.
    gcsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    // Update side: counters, stability test and result register.
    gcsc_back #(
        .PASSES  (PASSES),
        .SENSORS (SENSORS),
        .BOARDS  (BOARDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (w_q_stat),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule

// ===== hdl/gcsc_checker.sv =====
// ----------------------------------------------------------------------------
// gcsc_checker
// Port-level checks on the result channel of the stability check unit.
// ----------------------------------------------------------------------------
module gcsc_checker #(
    parameter int PASSES = 2
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ignored,
    input logic       i_stable,
    input logic [1:0] i_passes_done,
    input logic       i_complete,
    input logic [1:0] i_boards_seen
);

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // The complete flag agrees with the reported pass count.
    a_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_complete == (i_passes_done >= 2'(PASSES))))
        else $error("complete flag disagrees with pass count");

    // An ignored request never passes the stability test.
    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ignored) |-> !i_stable)
        else $error("ignored request reported stable");

    // A stable pass always advances the counter.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_stable) |-> (i_passes_done != 2'd0))
        else $error("stable pass with zero count");

    // Board 0 counts as seen from reset on.
    a_seen0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_boards_seen[0])
        else $error("board 0 seen flag lost");

endmodule

bind gray_coordinate_stability_check_unit gcsc_checker #(
    .PASSES (PASSES)
) u_gcsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ignored     (o_res.ignored),
    .i_stable      (o_res.stable),
    .i_passes_done (o_res.passes_done),
    .i_complete    (o_res.complete),
    .i_boards_seen (o_res.boards_seen)
);
